// File: rtl/spzp_pkg.sv
// Package: constants, types and lookup functions of the shaded point plotter.
`default_nettype none
package spzp_pkg;

	typedef logic signed [31:0] coord_t;

	// shared multiplier operand width
	localparam int MUL_W = 30;

	localparam int COT_Q16 = 371673;
	localparam logic signed [31:0] CAM_Q16 = 32'sd6553600;
	localparam logic signed [63:0] DEPTH_SUM_Q20 = 64'sd1048586486;
	localparam logic signed [63:0] DEPTH_PROD_Q52 = 64'sd687194767360;
	localparam logic [15:0] DENS_CAP_Q16 = 16'd64880;
	localparam logic [8:0] SPEC_EXP = 9'd300;
	localparam logic signed [31:0] LIGHT_X_Q16 = 32'sd327680;
	localparam logic signed [31:0] LIGHT_Y_Q16 = 32'sd65536;
	localparam logic signed [31:0] LIGHT_Z_Q16 = -32'sd5242880;

	typedef struct packed {
		logic signed [1:0] x;
		logic signed [1:0] y;
		logic signed [1:0] z;
	} normal_t;

	function automatic normal_t face_normal(input logic [2:0] face);
		normal_t n;
		n = '0;
		case (face)
			3'd0: n.z = 2'sd1;
			3'd1: n.z = -2'sd1;
			3'd2: n.y = -2'sd1;
			3'd3: n.y = 2'sd1;
			3'd4: n.x = -2'sd1;
			3'd5: n.x = 2'sd1;
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [6:0] glyph_of(input logic [4:0] gi);
		logic [6:0] g;
		case (gi)
			5'd0: g = 7'h40;
			5'd1: g = 7'h23;
			5'd2: g = 7'h57;
			5'd3: g = 7'h24;
			5'd4: g = 7'h39;
			5'd5: g = 7'h38;
			5'd6: g = 7'h36;
			5'd7: g = 7'h35;
			5'd8: g = 7'h33;
			5'd9: g = 7'h32;
			5'd10: g = 7'h30;
			5'd11: g = 7'h34;
			5'd12: g = 7'h37;
			5'd13: g = 7'h3F;
			5'd14: g = 7'h61;
			5'd15: g = 7'h62;
			5'd16: g = 7'h63;
			5'd17: g = 7'h31;
			5'd18: g = 7'h21;
			5'd19: g = 7'h3B;
			5'd20: g = 7'h3A;
			5'd21: g = 7'h2B;
			5'd22: g = 7'h3D;
			5'd23: g = 7'h2C;
			5'd24: g = 7'h2E;
			default: g = 7'h5F;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// File: rtl/spzp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module spzp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4050
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/shaded_point_zbuffer_plot_top.sv
// Top level: sequenced point projection, depth test and Blinn-Phong glyph shading.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: pos_x, pos_y, pos_z, face; tuser: action
// m_*       out  m_tvalid/m_tready    tdata: row, column, glyph
// cfg_*     in   cfg_we (no wait)     cfg_index selects trig register, cfg_data value
//
// Datapath: one beat at a time through one shared 30x30 multiplier, a radix-2
// restoring divider and a bit-pair square root. A plotted point takes 13 quotients
// and 3 roots; a clear sweeps every cell of the depth store.
// Reset: the depth store is swept to zero, with s_tready low meanwhile; trig
// registers take cos 1.0, sin 0.
// Stalls: s_tready is high only while idle; a finished result waits in the output
// register, and the next point halts before its store write if that is still full.
`default_nettype none
module shaded_point_zbuffer_plot_top #(
	parameter int SCREEN_WIDTH = 90,
	parameter int SCREEN_HEIGHT = 45
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [55:0] s_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32], face[50:48]
	input  wire  [0:0]  s_tuser,   // action[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // row[5:0], column[12:6], glyph[19:13]
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(SCREEN_WIDTH);
	localparam int RW = $clog2(SCREEN_HEIGHT);
	localparam logic signed [29:0] HCOT = 30'(SCREEN_HEIGHT * spzp_pkg::COT_Q16);
	localparam logic signed [63:0] HALF_W = 64'(SCREEN_WIDTH * 32768);
	localparam logic signed [63:0] HALF_H = 64'(SCREEN_HEIGHT * 32768);
	localparam logic signed [63:0] W_Q16 = 64'(SCREEN_WIDTH * 65536);
	localparam logic signed [63:0] H_Q16 = 64'(SCREEN_HEIGHT * 65536);
	localparam logic signed [63:0] NEG_ONE = -64'sd65536;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	// sequencer states
	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_ROT   = 5'd2;
	localparam logic [4:0] S_PZ    = 5'd3;
	localparam logic [4:0] S_SX    = 5'd4;
	localparam logic [4:0] S_SY    = 5'd5;
	localparam logic [4:0] S_SCR   = 5'd6;
	localparam logic [4:0] S_TDN   = 5'd7;
	localparam logic [4:0] S_DQDN  = 5'd8;
	localparam logic [4:0] S_DCMP  = 5'd9;
	localparam logic [4:0] S_UVSQ  = 5'd10;
	localparam logic [4:0] S_SQRT  = 5'd11;
	localparam logic [4:0] S_UVDIV = 5'd12;
	localparam logic [4:0] S_UVDQ  = 5'd13;
	localparam logic [4:0] S_UVEND = 5'd14;
	localparam logic [4:0] S_DOT   = 5'd15;
	localparam logic [4:0] S_POW   = 5'd16;
	localparam logic [4:0] S_FIN   = 5'd17;
	localparam logic [4:0] S_DPREP = 5'd18;
	localparam logic [4:0] S_DRUN  = 5'd19;
	localparam logic [4:0] S_DFIN  = 5'd20;

	// unit-vector job codes
	localparam logic [1:0] UV_EYE   = 2'd0;
	localparam logic [1:0] UV_LIGHT = 2'd1;
	localparam logic [1:0] UV_HALF  = 2'd2;
	localparam logic [1:0] UV_START = 2'd3;

	// config register indexes
	localparam logic [2:0] CFG_LAST = 3'd5;

	logic [4:0] state_q, ret_q;
	logic [6:0] cnt_q;
	logic [1:0] pair_q, rstep_q, k_q, uv_sel_q;
	logic rot_nrm_q;
	logic signed [15:0] trig_q [6];
	logic [2:0] face_q;

	spzp_pkg::coord_t rx_q, ry_q, rz_q, nu_q, px_q, py_q, pz_q;
	spzp_pkg::coord_t n_q [3];
	spzp_pkg::coord_t e_q [3];
	spzp_pkg::coord_t l_q [3];
	spzp_pkg::coord_t h_q [3];
	spzp_pkg::coord_t v_q [3];
	spzp_pkg::coord_t u_q [3];

	logic signed [63:0] acc_q, sxq_q;
	logic signed [63:0] dnum_q, dden_q, dres_q;
	logic [63:0] drem_q, dquo_q;
	logic dneg_q;
	logic [63:0] sqv_q, sqr_q, sqbit_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] idx_q, clr_addr_q;
	logic [31:0] depth_q, diff_q, spec_q;
	logic [16:0] pr_q, pb_q;
	logic [3:0] pbit_q;
	logic pph_q;
	logic out_valid_q;
	logic [6:0] out_glyph_q, out_col_q;
	logic [5:0] out_row_q;

	// shared multiplier
	logic signed [29:0] mul_a, mul_b;
	logic signed [59:0] mul_p;
	logic signed [63:0] mul_p64;

	// rotation operand selection
	logic signed [15:0] rot_c, rot_s;
	spzp_pkg::coord_t rot_u, rot_w;
	logic [1:0] dot_j;
	logic dot_hi;

	always_comb begin
		case (pair_q)
			2'd0: begin
				rot_c = trig_q[0]; rot_s = trig_q[1]; rot_u = ry_q; rot_w = rz_q;
			end
			2'd1: begin
				rot_c = trig_q[2]; rot_s = trig_q[3]; rot_u = rx_q; rot_w = rz_q;
			end
			default: begin
				rot_c = trig_q[4]; rot_s = trig_q[5]; rot_u = rx_q; rot_w = ry_q;
			end
		endcase
	end

	assign dot_hi = (cnt_q[2:0] >= 3'd3);
	assign dot_j = dot_hi ? 2'(cnt_q[2:0] - 3'd3) : cnt_q[1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ROT: begin
				case (rstep_q)
					2'd0: begin mul_a = 30'(rot_c); mul_b = rot_u[29:0]; end
					2'd1: begin mul_a = 30'(rot_s); mul_b = rot_w[29:0]; end
					2'd2: begin mul_a = 30'(rot_c); mul_b = rot_w[29:0]; end
					default: begin mul_a = 30'(rot_s); mul_b = rot_u[29:0]; end
				endcase
			end
			S_PZ: begin mul_a = rx_q[29:0]; mul_b = HCOT; end
			S_SX: begin mul_a = py_q[29:0]; mul_b = HCOT; end
			S_UVSQ: begin mul_a = v_q[k_q][29:0]; mul_b = v_q[k_q][29:0]; end
			S_DOT: begin
				mul_a = dot_hi ? h_q[dot_j][29:0] : n_q[dot_j][29:0];
				mul_b = dot_hi ? n_q[dot_j][29:0] : l_q[dot_j][29:0];
			end
			S_POW: begin
				mul_a = pph_q ? 30'(pb_q) : 30'(pr_q);
				mul_b = 30'(pb_q);
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign mul_p64 = 64'(mul_p);

	// combinational helpers for the current step
	logic signed [63:0] rot_sum, uv_sum, dot_sum, syq, asum, amag, pz_ext;
	logic [64:0] rem_sh;
	logic [63:0] sq_trial;
	spzp_pkg::coord_t pzv;
	spzp_pkg::normal_t nrm;
	logic off_screen;
	logic fin_go;
	logic [32:0] dsum;
	logic [31:0] dhalf;
	logic [15:0] dens;
	logic [20:0] gprod;
	logic [31:0] pow_sq;

	always_comb begin
		rot_sum = (rstep_q == 2'd1) ? (acc_q + mul_p64) : (acc_q - mul_p64);
		uv_sum = ((k_q == 2'd0) ? 64'sd0 : acc_q) + mul_p64;
		dot_sum = ((cnt_q[2:0] == 3'd0 || cnt_q[2:0] == 3'd3) ? 64'sd0 : acc_q) + mul_p64;
		pzv = rz_q - spzp_pkg::CAM_Q16;
		pz_ext = 64'(pz_q);
		syq = HALF_H + dres_q;
		off_screen = (sxq_q <= NEG_ONE) || (sxq_q >= W_Q16) ||
			(syq <= NEG_ONE) || (syq >= H_Q16);
		asum = spzp_pkg::DEPTH_SUM_Q20 + dres_q;
		amag = asum[63] ? -asum : asum;
		rem_sh = {drem_q, dquo_q[63]};
		sq_trial = sqr_q + sqbit_q;
		nrm = spzp_pkg::face_normal(face_q);
		fin_go = !out_valid_q || m_tready;
		dsum = {1'b0, diff_q} + {1'b0, spec_q};
		dhalf = dsum[32:1];
		dens = (dhalf > 32'(spzp_pkg::DENS_CAP_Q16)) ? spzp_pkg::DENS_CAP_Q16 : dhalf[15:0];
		gprod = 21'(dens) * 21'd26;
		pow_sq = mul_p[47:16];
	end

	// depth store
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0] ram_wdata, ram_rdata;

	assign ram_we = (state_q == S_CLEAR) || (state_q == S_FIN && fin_go);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_addr_q : idx_q;
	assign ram_wdata = (state_q == S_CLEAR) ? 32'd0 : depth_q;

	spzp_ram #(
		.WIDTH(32),
		.DEPTH(CELLS)
	) u_depth (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, out_glyph_q, out_col_q, out_row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_IDLE;
			cnt_q <= '0;
			pair_q <= '0;
			rstep_q <= '0;
			k_q <= '0;
			uv_sel_q <= UV_START;
			rot_nrm_q <= 1'b0;
			trig_q[0] <= 16'sd16384;
			trig_q[1] <= 16'sd0;
			trig_q[2] <= 16'sd16384;
			trig_q[3] <= 16'sd0;
			trig_q[4] <= 16'sd16384;
			trig_q[5] <= 16'sd0;
			face_q <= '0;
			rx_q <= '0; ry_q <= '0; rz_q <= '0; nu_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= '0; e_q[i] <= '0; l_q[i] <= '0;
				h_q[i] <= '0; v_q[i] <= '0; u_q[i] <= '0;
			end
			acc_q <= '0; sxq_q <= '0;
			dnum_q <= '0; dden_q <= '0; dres_q <= '0;
			drem_q <= '0; dquo_q <= '0; dneg_q <= 1'b0;
			sqv_q <= '0; sqr_q <= '0; sqbit_q <= '0;
			col_q <= '0; row_q <= '0; idx_q <= '0; clr_addr_q <= '0;
			depth_q <= '0; diff_q <= '0; spec_q <= '0;
			pr_q <= '0; pb_q <= '0; pbit_q <= '0; pph_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_glyph_q <= '0; out_col_q <= '0; out_row_q <= '0;
		end else begin
			// trig registers: writes beyond the list are dropped
			if (cfg_we && cfg_index <= CFG_LAST) begin
				trig_q[cfg_index] <= cfg_data;
			end

			// drain the output register
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					// sweep one cell a cycle
					if (clr_addr_q == LAST_CELL) begin
						clr_addr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end

				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) begin
							clr_addr_q <= '0;
							state_q <= S_CLEAR;
						end else begin
							// Q8.8 into Q16.16
							rx_q <= {{8{s_tdata[15]}}, s_tdata[15:0], 8'd0};
							ry_q <= {{8{s_tdata[31]}}, s_tdata[31:16], 8'd0};
							rz_q <= {{8{s_tdata[47]}}, s_tdata[47:32], 8'd0};
							face_q <= s_tdata[50:48];
							pair_q <= '0;
							rstep_q <= '0;
							rot_nrm_q <= 1'b0;
							state_q <= S_ROT;
						end
					end
				end

				S_ROT: begin
					// four products per axis pair: u' = (c*u + s*w)>>14, w' = (c*w - s*u)>>14
					case (rstep_q)
						2'd0, 2'd2: acc_q <= mul_p64;
						2'd1: nu_q <= 32'(rot_sum >>> 14);
						default: begin
							case (pair_q)
								2'd0: begin ry_q <= nu_q; rz_q <= 32'(rot_sum >>> 14); end
								2'd1: begin rx_q <= nu_q; rz_q <= 32'(rot_sum >>> 14); end
								default: begin rx_q <= nu_q; ry_q <= 32'(rot_sum >>> 14); end
							endcase
						end
					endcase
					rstep_q <= rstep_q + 1'b1;
					if (rstep_q == 2'd3) begin
						if (pair_q == 2'd2) begin
							pair_q <= '0;
							state_q <= rot_nrm_q ? S_UVEND : S_PZ;
						end else begin
							pair_q <= pair_q + 1'b1;
						end
					end
				end

				S_PZ: begin
					// move into view space; drop a point on the camera plane
					px_q <= rx_q;
					py_q <= ry_q;
					pz_q <= pzv;
					if (pzv == 32'sd0) begin
						state_q <= S_IDLE;
					end else begin
						dnum_q <= mul_p64;
						dden_q <= 64'(pzv);
						ret_q <= S_SX;
						state_q <= S_DPREP;
					end
				end

				S_SX: begin
					sxq_q <= HALF_W - dres_q;
					dnum_q <= mul_p64;
					dden_q <= pz_ext <<< 1;
					ret_q <= S_SY;
					state_q <= S_DPREP;
				end

				S_SY: begin
					if (off_screen) begin
						state_q <= S_IDLE;
					end else begin
						col_q <= (sxq_q <= 64'sd0) ? '0 : sxq_q[16 +: CW];
						row_q <= (syq <= 64'sd0) ? '0 : syq[16 +: RW];
						state_q <= S_SCR;
					end
				end

				S_SCR: begin
					// address the cell; its stored depth is read while depth is worked out
					idx_q <= AW'(32'(row_q) * SCREEN_WIDTH + 32'(col_q));
					dnum_q <= spzp_pkg::DEPTH_PROD_Q52;
					dden_q <= pz_ext;
					ret_q <= S_TDN;
					state_q <= S_DPREP;
				end

				S_TDN: begin
					if (amag == 64'sd0) begin
						depth_q <= 32'hFFFF_FFFF;
						state_q <= S_DCMP;
					end else begin
						dnum_q <= 64'sd1 <<< 61;
						dden_q <= amag;
						ret_q <= S_DQDN;
						state_q <= S_DPREP;
					end
				end

				S_DQDN: begin
					depth_q <= (dres_q > 64'sh0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
						: dres_q[31:0];
					state_q <= S_DCMP;
				end

				S_DCMP: begin
					// not strictly nearer: drop
					if (depth_q <= ram_rdata) begin
						state_q <= S_IDLE;
					end else begin
						rx_q <= {{14{nrm.x[1]}}, nrm.x, 16'd0};
						ry_q <= {{14{nrm.y[1]}}, nrm.y, 16'd0};
						rz_q <= {{14{nrm.z[1]}}, nrm.z, 16'd0};
						pair_q <= '0;
						rstep_q <= '0;
						rot_nrm_q <= 1'b1;
						uv_sel_q <= UV_START;
						state_q <= S_ROT;
					end
				end

				S_UVSQ: begin
					// sum of squares, one component a cycle
					acc_q <= uv_sum;
					if (k_q == 2'd2) begin
						sqv_q <= uv_sum;
						sqr_q <= '0;
						sqbit_q <= 64'd1 << 62;
						cnt_q <= '0;
						state_q <= S_SQRT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end

				S_SQRT: begin
					if (sqv_q >= sq_trial) begin
						sqv_q <= sqv_q - sq_trial;
						sqr_q <= (sqr_q >> 1) + sqbit_q;
					end else begin
						sqr_q <= sqr_q >> 1;
					end
					sqbit_q <= sqbit_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd31) begin
						k_q <= '0;
						state_q <= S_UVDIV;
					end
				end

				S_UVDIV: begin
					// zero length gives a zero unit vector
					if (sqr_q == 64'd0) begin
						for (int i = 0; i < 3; i++) begin
							u_q[i] <= '0;
						end
						state_q <= S_UVEND;
					end else begin
						dnum_q <= {{16{v_q[k_q][31]}}, v_q[k_q], 16'd0};
						dden_q <= sqr_q;
						ret_q <= S_UVDQ;
						state_q <= S_DPREP;
					end
				end

				S_UVDQ: begin
					u_q[k_q] <= dres_q[31:0];
					if (k_q == 2'd2) begin
						state_q <= S_UVEND;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_UVDIV;
					end
				end

				S_UVEND: begin
					k_q <= '0;
					case (uv_sel_q)
						UV_START: begin
							n_q[0] <= rx_q; n_q[1] <= ry_q; n_q[2] <= rz_q;
							v_q[0] <= -px_q; v_q[1] <= -py_q; v_q[2] <= -pz_q;
							uv_sel_q <= UV_EYE;
							state_q <= S_UVSQ;
						end
						UV_EYE: begin
							for (int i = 0; i < 3; i++) begin
								e_q[i] <= u_q[i];
							end
							v_q[0] <= spzp_pkg::LIGHT_X_Q16 - px_q;
							v_q[1] <= spzp_pkg::LIGHT_Y_Q16 - py_q;
							v_q[2] <= spzp_pkg::LIGHT_Z_Q16 - pz_q;
							uv_sel_q <= UV_LIGHT;
							state_q <= S_UVSQ;
						end
						UV_LIGHT: begin
							for (int i = 0; i < 3; i++) begin
								l_q[i] <= u_q[i];
								v_q[i] <= u_q[i] + e_q[i];
							end
							uv_sel_q <= UV_HALF;
							state_q <= S_UVSQ;
						end
						default: begin
							for (int i = 0; i < 3; i++) begin
								h_q[i] <= u_q[i];
							end
							cnt_q <= '0;
							state_q <= S_DOT;
						end
					endcase
				end

				S_DOT: begin
					// n.l then h.n, floored to Q16.16 and clamped at zero
					acc_q <= dot_sum;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[2:0] == 3'd2) begin
						diff_q <= dot_sum[63] ? 32'd0 : 32'(dot_sum >>> 16);
					end
					if (cnt_q[2:0] == 3'd5) begin
						if (!dot_sum[63] && (dot_sum >>> 16) > 64'sd65536) begin
							spec_q <= 32'h7FFF_FFFF;
							state_q <= S_FIN;
						end else begin
							pr_q <= 17'd65536;
							pb_q <= dot_sum[63] ? 17'd0 : dot_sum[32:16];
							pbit_q <= '0;
							pph_q <= 1'b0;
							state_q <= S_POW;
						end
					end
				end

				S_POW: begin
					// square and multiply over the exponent bits, low bit first
					if (!pph_q) begin
						if (SPEC_EXP_BIT(pbit_q)) begin
							pr_q <= pow_sq[16:0];
						end
						pph_q <= 1'b1;
					end else begin
						pb_q <= pow_sq[16:0];
						pph_q <= 1'b0;
						pbit_q <= pbit_q + 1'b1;
						if (pbit_q == 4'd8) begin
							spec_q <= 32'(pr_q);
							state_q <= S_FIN;
						end
					end
				end

				S_FIN: begin
					// hold until the output register is free, then commit depth and result
					if (fin_go) begin
						out_valid_q <= 1'b1;
						out_row_q <= 6'(row_q);
						out_col_q <= 7'(col_q);
						out_glyph_q <= spzp_pkg::glyph_of(gprod[20:16]);
						state_q <= S_IDLE;
					end
				end

				S_DPREP: begin
					dneg_q <= dnum_q[63] ^ dden_q[63];
					dquo_q <= dnum_q[63] ? 64'(-dnum_q) : 64'(dnum_q);
					dden_q <= dden_q[63] ? -dden_q : dden_q;
					drem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DRUN;
				end

				S_DRUN: begin
					// one quotient bit a cycle
					if (rem_sh >= {1'b0, dden_q}) begin
						drem_q <= 64'(rem_sh - {1'b0, dden_q});
						dquo_q <= {dquo_q[62:0], 1'b1};
					end else begin
						drem_q <= rem_sh[63:0];
						dquo_q <= {dquo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd63) begin
						state_q <= S_DFIN;
					end
				end

				S_DFIN: begin
					dres_q <= dneg_q ? -$signed(dquo_q) : $signed(dquo_q);
					state_q <= ret_q;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	function automatic logic SPEC_EXP_BIT(input logic [3:0] b);
		return (b <= 4'd8) ? spzp_pkg::SPEC_EXP[b[3:0] > 4'd8 ? 4'd8 : b] : 1'b0;
	endfunction

endmodule
`default_nettype wire

// File: tb/shaded_point_zbuffer_plot_top_tb.sv
// Testbench for the shaded point plotter: directed and random points against a built-in depth/shade predictor.
`timescale 1ns / 1ps
module shaded_point_zbuffer_plot_top_tb;
	import spzp_pkg::*;

	localparam int W = 90;
	localparam int H = 45;
	localparam int CELLS = W * H;
	// Idle time after the last result: a clear sweeps W*H cells and a plot runs its
	// divisions and square roots, so wait comfortably longer than both.
	localparam int SETTLE = 6000;
	localparam longint LIMIT = 40_000_000;

	// Trig register indexes, in the order of the register list
	localparam logic [2:0] REG_COS_X = 3'd0;
	localparam logic [2:0] REG_SIN_X = 3'd1;
	localparam logic [2:0] REG_COS_Y = 3'd2;
	localparam logic [2:0] REG_SIN_Y = 3'd3;
	localparam logic [2:0] REG_COS_Z = 3'd4;
	localparam logic [2:0] REG_SIN_Z = 3'd5;

	localparam bit ACT_PLOT = 1'b0;
	localparam bit ACT_CLEAR = 1'b1;

	typedef struct {
		bit          action;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [2:0]  face;
	} point_t;

	typedef struct {
		logic [5:0] row;
		logic [6:0] column;
		logic [6:0] glyph;
	} cell_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;    // pos_x, pos_y, pos_z, face, zero fill
	logic [0:0]  s_tuser;    // action
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // row, column, glyph, zero fill
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	shaded_point_zbuffer_plot_top #(.SCREEN_WIDTH(W), .SCREEN_HEIGHT(H)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor state: its own copy of the depth store and trig registers
	logic [31:0]        zdepth [CELLS];
	logic signed [15:0] trig [6];
	string              glyph_ramp = "@#W$986532047?abc1!;:+=,._";

	point_t  pending_points[$];
	cell_t   expected_cells[$];
	int      errors = 0;
	int      beats_sent = 0;
	int      beats_taken = 0;
	int      cells_seen = 0;
	int      clears_sent = 0;
	int      phases_run = 0;
	longint  cycles = 0;
	bit      idle_on = 1'b1;

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void turn(inout longint u, inout longint w,
			input longint c, input longint s);
		longint nu, nw;
		nu = (c * u + s * w) >>> 14;
		nw = (c * w - s * u) >>> 14;
		u = nu;
		w = nw;
	endfunction

	// Rotate about x, then y, then z
	function automatic void rotate3(inout longint v[3]);
		turn(v[1], v[2], longint'(trig[REG_COS_X]), longint'(trig[REG_SIN_X]));
		turn(v[0], v[2], longint'(trig[REG_COS_Y]), longint'(trig[REG_SIN_Y]));
		turn(v[0], v[1], longint'(trig[REG_COS_Z]), longint'(trig[REG_SIN_Z]));
	endfunction

	function automatic void unit3(input longint v[3], output longint o[3]);
		longint unsigned sum, m;
		longint len;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m = v[i] < 0 ? -v[i] : v[i];
			sum += m * m;
		end
		len = longint'(isqrt(sum));
		for (int i = 0; i < 3; i++)
			o[i] = len == 0 ? 0 : (v[i] * 65536) / len;
	endfunction

	function automatic longint dot3(input longint a[3], input longint b[3]);
		return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16;
	endfunction

	function automatic longint spec_power(input longint x);
		longint unsigned r, b;
		int e;
		if (x > 65536)
			return 64'h7FFFFFFF;
		r = 65536;
		b = x;
		e = 300;
		while (e != 0) begin
			if (e & 1)
				r = (r * b) >> 16;
			b = (b * b) >> 16;
			e >>= 1;
		end
		return longint'(r);
	endfunction

	// Work out whether a point lands, update the depth store, and shade it; a clear wipes the store
	function automatic bit plot_point(input point_t it, output cell_t res);
		longint p[3], n[3], e[3], ld[3], hv[3], tmp[3];
		longint sxq, syq, t, a, diff, spec, dens;
		longint unsigned dq;
		logic [31:0] depth;
		int col, row, idx, gi;
		res = '{default: '0};
		if (it.action == ACT_CLEAR) begin
			foreach (zdepth[i])
				zdepth[i] = '0;
			return 0;
		end
		p[0] = longint'($signed(it.x)) * 256;
		p[1] = longint'($signed(it.y)) * 256;
		p[2] = longint'($signed(it.z)) * 256;
		rotate3(p);
		p[2] -= 64'sd6553600;
		if (p[2] == 0)
			return 0;
		sxq = longint'(W) * 32768 - (longint'(H) * 371673 * p[0]) / p[2];
		syq = longint'(H) * 32768 + (longint'(H) * 371673 * p[1]) / (2 * p[2]);
		if (sxq <= -65536 || sxq >= longint'(W) * 65536)
			return 0;
		if (syq <= -65536 || syq >= longint'(H) * 65536)
			return 0;
		col = sxq <= 0 ? 0 : int'(sxq >>> 16);
		row = syq <= 0 ? 0 : int'(syq >>> 16);
		idx = row * W + col;
		if (idx >= CELLS)
			return 0;

		t = 64'sd687194767360 / p[2];
		a = 64'sd1048586486 + t;
		if (a < 0)
			a = -a;
		if (a == 0) begin
			depth = '1;
		end else begin
			dq = (64'd1 << 61) / longint'(a);
			depth = dq > 64'hFFFFFFFF ? 32'hFFFFFFFF : dq[31:0];
		end
		if (depth <= zdepth[idx])
			return 0;

		n = '{0, 0, 0};
		case (it.face)
			3'd0: n[2] = 65536;
			3'd1: n[2] = -65536;
			3'd2: n[1] = -65536;
			3'd3: n[1] = 65536;
			3'd4: n[0] = -65536;
			3'd5: n[0] = 65536;
			default: ;
		endcase
		rotate3(n);

		for (int i = 0; i < 3; i++)
			tmp[i] = -p[i];
		unit3(tmp, e);
		tmp[0] = 5 * 65536 - p[0];
		tmp[1] = 65536 - p[1];
		tmp[2] = -80 * 65536 - p[2];
		unit3(tmp, ld);
		diff = dot3(n, ld);
		if (diff < 0)
			diff = 0;
		for (int i = 0; i < 3; i++)
			tmp[i] = ld[i] + e[i];
		unit3(tmp, hv);
		t = dot3(hv, n);
		spec = spec_power(t < 0 ? 0 : t);
		dens = (diff + spec) / 2;
		if (dens > 64880)
			dens = 64880;
		gi = int'((dens * 26) >>> 16);
		if (gi > 25)
			gi = 25;

		zdepth[idx] = depth;
		res.row = row[5:0];
		res.column = col[6:0];
		res.glyph = glyph_ramp[gi][6:0];
		return 1;
	endfunction

	// Mostly short gaps, a few long ones; none while idling is off
	function automatic int gap_len();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// Sender: present one beat at a time from the pending queue
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && beats_taken != beats_sent)) begin
			// the bus is idle or its beat was taken; the next branch loads a new one after any gap, if one is queued
		end
		if (arst_n && (!s_tvalid || beats_taken == beats_sent)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				point_t it;
				it = pending_points.pop_front();
				s_tdata <= {5'b0, it.face, it.z, it.y, it.x};
				s_tuser <= it.action;
				s_tvalid <= 1'b1;
				beats_sent <= beats_sent + 1;
				send_gap <= gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure
	int recv_gap = 0;
	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			recv_gap <= gap_len();
		end
	end

	// Monitor: predict on each accepted input beat, check each output beat
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && s_tvalid && s_tready) begin
			point_t it;
			cell_t c;
			it.x = s_tdata[15:0];
			it.y = s_tdata[31:16];
			it.z = s_tdata[47:32];
			it.face = s_tdata[50:48];
			it.action = s_tuser[0];
			beats_taken <= beats_taken + 1;
			if (plot_point(it, c))
				expected_cells.push_back(c);
		end
		if (arst_n && m_tvalid && m_tready) begin
			cell_t c;
			cells_seen <= cells_seen + 1;
			if (expected_cells.size() == 0) begin
				$error("unexpected result beat %h", m_tdata);
				errors <= errors + 1;
			end else begin
				c = expected_cells.pop_front();
				if (m_tdata[5:0] !== c.row) begin
					$error("row: expected %0d, actual %0d", c.row, m_tdata[5:0]);
					errors <= errors + 1;
				end
				if (m_tdata[12:6] !== c.column) begin
					$error("column: expected %0d, actual %0d", c.column, m_tdata[12:6]);
					errors <= errors + 1;
				end
				if (m_tdata[19:13] !== c.glyph) begin
					$error("glyph: expected %h, actual %h", c.glyph, m_tdata[19:13]);
					errors <= errors + 1;
				end
			end
		end
	end

	task automatic add_point(input bit act, input int x, input int y, input int z,
			input int face);
		point_t it;
		it.action = act;
		it.x = x[15:0];
		it.y = y[15:0];
		it.z = z[15:0];
		it.face = face[2:0];
		pending_points.push_back(it);
		if (act == ACT_CLEAR)
			clears_sent++;
	endtask

	// Block until every queued beat is taken and every result has come back
	task automatic drain();
		while (pending_points.size() != 0 || s_tvalid || beats_sent != beats_taken)
			@(posedge clk);
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_trig(input logic [2:0] idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		trig[idx] = value[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Load one angle set as Q1.14 cos/sin pairs
	task automatic set_angles(input real ax, input real ay, input real az);
		write_trig(REG_COS_X, int'($cos(ax) * 16384.0));
		write_trig(REG_SIN_X, int'($sin(ax) * 16384.0));
		write_trig(REG_COS_Y, int'($cos(ay) * 16384.0));
		write_trig(REG_SIN_Y, int'($sin(ay) * 16384.0));
		write_trig(REG_COS_Z, int'($cos(az) * 16384.0));
		write_trig(REG_SIN_Z, int'($sin(az) * 16384.0));
	endtask

	// A point on the surface of a cube of random size, with its face
	task automatic add_cube_point();
		int half, u, v, f;
		half = $urandom_range(4000, 256);
		u = $urandom_range(2 * half) - half;
		v = $urandom_range(2 * half) - half;
		f = $urandom_range(5);
		case (f)
			0: add_point(ACT_PLOT, u, v, half, f);
			1: add_point(ACT_PLOT, u, v, -half, f);
			2: add_point(ACT_PLOT, u, -half, v, f);
			3: add_point(ACT_PLOT, u, half, v, f);
			4: add_point(ACT_PLOT, -half, u, v, f);
			default: add_point(ACT_PLOT, half, u, v, f);
		endcase
	endtask

	task automatic add_random_phase(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 3)
				add_point(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom_range(7));
			else if (r < 83)
				add_cube_point();
			else if (r < 92)
				add_point(ACT_PLOT, $urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
					$urandom_range(8000) - 4000, $urandom_range(7));
			else
				add_point(ACT_PLOT, $urandom, $urandom, $urandom, $urandom_range(7));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COS_X;
		cfg_data = '0;
		foreach (zdepth[i])
			zdepth[i] = '0;
		trig[REG_COS_X] = 16384; trig[REG_SIN_X] = 0;
		trig[REG_COS_Y] = 16384; trig[REG_SIN_Y] = 0;
		trig[REG_COS_Z] = 16384; trig[REG_SIN_Z] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset angles
		add_point(ACT_PLOT, 0, 0, 0, 0);                 // center of the screen
		add_point(ACT_PLOT, 0, 0, 0, 0);                 // same depth again: no update
		add_point(ACT_PLOT, 0, 0, 256, 0);               // nearer in the same cell
		for (int f = 0; f < 8; f++)                      // every face, unused codes too
			add_point(ACT_PLOT, 512 * (f - 4), 300 * (f - 3), 1280, f);
		add_point(ACT_PLOT, 0, 0, 25600, 1);             // view depth exactly zero
		add_point(ACT_PLOT, 1000, 500, 30720, 3);        // behind the camera
		add_point(ACT_PLOT, 32767, 32767, 32767, 5);     // field extremes
		add_point(ACT_PLOT, -32768, -32768, -32768, 4);
		add_point(ACT_PLOT, 4400, 0, 0, 5);              // near the left/right edges
		add_point(ACT_PLOT, -4400, 0, 0, 4);
		add_point(ACT_PLOT, 0, 4400, 0, 3);
		add_point(ACT_PLOT, 0, -4400, 0, 2);
		add_point(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7);  // clear, fields ignored
		add_point(ACT_PLOT, 0, 0, 0, 0);                 // plots again after the clear
		drain();

		// Angle sets: +-1.0 in Q1.14, off-circle values, then random
		write_trig(REG_COS_X, -16384); write_trig(REG_SIN_X, 16384);
		write_trig(REG_COS_Y, 16384);  write_trig(REG_SIN_Y, -16384);
		write_trig(REG_COS_Z, -16384); write_trig(REG_SIN_Z, -16384);
		add_point(ACT_CLEAR, 0, 0, 0, 0);
		add_random_phase(150);
		drain();
		phases_run++;

		for (int ph = 0; ph < 7; ph++) begin
			idle_on = (ph % 3) != 1;
			if (ph == 2) begin
				write_trig(REG_COS_X, $urandom_range(32768) - 16384);
				write_trig(REG_SIN_X, $urandom_range(32768) - 16384);
				write_trig(REG_COS_Y, $urandom_range(32768) - 16384);
				write_trig(REG_SIN_Y, $urandom_range(32768) - 16384);
				write_trig(REG_COS_Z, $urandom_range(32768) - 16384);
				write_trig(REG_SIN_Z, $urandom_range(32768) - 16384);
			end else begin
				set_angles($urandom_range(6283) / 1000.0, $urandom_range(6283) / 1000.0,
					$urandom_range(6283) / 1000.0);
			end
			add_point(ACT_CLEAR, 0, 0, 0, 0);
			add_random_phase(150);
			drain();
			phases_run++;
		end

		$display("Covered %0d input beats (%0d clears) over %0d angle sets; %0d cells drawn.",
			beats_taken, clears_sent, phases_run + 1, cells_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
